// ----- hdl/xcfr_pkg.sv -----
// Package for the XOR-checked frame receiver.
// Holds phase encoding, status codes, register indexes and frame constants.
// No dependencies.
`timescale 1ns / 1ps

package xcfr_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_CSUM    = 3'd2,
        ST_BADLEN  = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [7:0]  MIN_FRAME_LEN     = 8'd3;
    localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
    localparam logic [15:0] TIMER_MAX         = 16'hFFFF;

endpackage

// ----- hdl/xor_checked_frame_receiver_top.sv -----
// Top level of the XOR-checked frame receiver.
// Uses xcfr_pkg for phase encoding, status codes and register indexes.
`timescale 1ns / 1ps
//
// Usage:
//   s_* channel: one transaction per serial byte (s_command = 0, s_rx_byte)
//   or per time tick (s_command = 1). m_* channel: one transaction per
//   forwarded frame byte or per timeout, with position, end flag and verdict.
//   cfg_* channel: writes header_first (0), header_second (1) and
//   timeout_ticks (2); index 3 is ignored. Writes are taken at once and
//   must only be issued while the receiver is idle.
// Timing:
//   An input transaction is registered in the input stage, then decoded
//   against the frame state in a single pass into the output register,
//   which offers the result on m_*. One input per cycle is sustained while
//   m_ready stays high; the frame state update is the only loop.
// Reset: aresetn low clears both stages, restores register defaults and
//   puts the receiver in header hunt.
// Stall: while m_ready is low with a result pending, the input stage holds
//   one more transaction, then s_ready drops until the result is taken.

module xor_checked_frame_receiver_top
    import xcfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_byte_index,
    output logic        m_last,
    output logic [2:0]  m_status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;
    logic [15:0] timeout_ticks_reg;

    logic        in_valid_reg;
    logic        in_command_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [15:0] wait_timer_reg, wait_timer_next;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg, out_data_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic        out_last_reg, out_last_next;
    status_t     out_status_reg, out_status_next;
    logic        res_valid;

    logic        advance;
    logic [15:0] timer_inc;
    logic [8:0]  count_plus_one;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_valid_reg;
    assign m_data_byte  = out_data_reg;
    assign m_byte_index = out_index_reg;
    assign m_last       = out_last_reg;
    assign m_status     = out_status_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                REG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg <= s_command;
            in_byte_reg    <= s_rx_byte;
        end
    end

    assign timer_inc      = (wait_timer_reg != TIMER_MAX) ? wait_timer_reg + 16'd1
                                                          : wait_timer_reg;
    assign count_plus_one = {1'b0, byte_count_reg} + 9'd1;

    // frame decode
    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        running_xor_next  = running_xor_reg;
        wait_timer_next   = wait_timer_reg;
        res_valid         = 1'b0;
        out_data_next     = in_byte_reg;
        out_index_next    = byte_count_reg;
        out_last_next     = 1'b0;
        out_status_next   = ST_BUSY;

        if (in_command_reg == CMD_TICK) begin
            if (phase_reg != PH_HUNT) begin
                wait_timer_next = timer_inc;
                if (timer_inc >= timeout_ticks_reg) begin
                    res_valid         = 1'b1;
                    out_data_next     = 8'd0;
                    out_last_next     = 1'b1;
                    out_status_next   = ST_TIMEOUT;
                    phase_next        = PH_HUNT;
                    byte_count_next   = 8'd0;
                    frame_length_next = 8'd0;
                    running_xor_next  = 8'd0;
                    wait_timer_next   = 16'd0;
                end
            end
        end else begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte_reg == header_first_reg ||
                        in_byte_reg == header_second_reg) begin
                        res_valid         = 1'b1;
                        out_index_next    = 8'd0;
                        running_xor_next  = in_byte_reg;
                        byte_count_next   = 8'd1;
                        frame_length_next = 8'd0;
                        wait_timer_next   = 16'd0;
                        phase_next        = PH_LEN;
                    end
                end
                PH_LEN: begin
                    res_valid      = 1'b1;
                    out_index_next = 8'd1;
                    if (in_byte_reg < MIN_FRAME_LEN) begin
                        out_last_next     = 1'b1;
                        out_status_next   = ST_BADLEN;
                        phase_next        = PH_HUNT;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_xor_next  = 8'd0;
                        wait_timer_next   = 16'd0;
                    end else begin
                        frame_length_next = in_byte_reg;
                        running_xor_next  = running_xor_reg ^ in_byte_reg;
                        byte_count_next   = 8'd2;
                        wait_timer_next   = 16'd0;
                        phase_next        = PH_BODY;
                    end
                end
                PH_BODY: begin
                    res_valid = 1'b1;
                    if (count_plus_one >= {1'b0, frame_length_reg}) begin
                        out_last_next     = 1'b1;
                        out_status_next   = (in_byte_reg == running_xor_reg) ? ST_GOOD
                                                                              : ST_CSUM;
                        phase_next        = PH_HUNT;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_xor_next  = 8'd0;
                        wait_timer_next   = 16'd0;
                    end else begin
                        running_xor_next = running_xor_reg ^ in_byte_reg;
                        byte_count_next  = count_plus_one[7:0];
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            byte_count_reg   <= 8'd0;
            frame_length_reg <= 8'd0;
            running_xor_reg  <= 8'd0;
            wait_timer_reg   <= 16'd0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            running_xor_reg  <= running_xor_next;
            wait_timer_reg   <= wait_timer_next;
        end
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg   <= out_data_next;
            out_index_reg  <= out_index_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    // checks
    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT |-> byte_count_reg == 8'd0 && running_xor_reg == 8'd0
                                 && wait_timer_reg == 16'd0)
        else $error("hunt phase with stale frame state");

    a_last_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_last_reg == (out_status_reg != ST_BUSY)))
        else $error("end flag and verdict disagree");

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == ST_TIMEOUT |-> out_data_reg == 8'd0)
        else $error("timeout result carries data");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && !advance == !s_ready)
        else $error("input stage lost transaction during stall");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> byte_count_reg >= 8'd2 && byte_count_reg < frame_length_reg)
        else $error("body byte count out of frame");

endmodule

// ----- tb/sv/xor_checked_frame_receiver_top_test.sv -----
// Self-checking testbench for xor_checked_frame_receiver_top.
// Drives bytes and ticks, predicts every forwarded byte and verdict, compares on m_*.
// Depends on xcfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module xor_checked_frame_receiver_top_test;
    import xcfr_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       last;
        status_t    status;
    } rx_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_BYTE;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_data_byte;
    logic [7:0]  m_byte_index;
    logic        m_last;
    logic [2:0]  m_status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_UNUSED;
    logic [15:0] cfg_data  = 16'd0;

    // predicted receiver state and register copies
    phase_t      rx_phase;
    logic [7:0]  rx_count;
    logic [7:0]  rx_length;
    logic [7:0]  rx_xor;
    logic [15:0] rx_timer;
    logic [7:0]  cfg_hdr_a;
    logic [7:0]  cfg_hdr_b;
    logic [15:0] cfg_timeout;

    rx_beat_t    expected_beats[$];
    int          beats_predicted = 0;
    int          items_sent      = 0;
    int          error_count     = 0;
    int          cycle_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;

    xor_checked_frame_receiver_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .m_status     (m_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        rx_beat_t want;
        if (m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result: data_byte %0d byte_index %0d status %0d",
                       m_data_byte, m_byte_index, m_status);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0d, actual %0d", want.data_byte, m_data_byte);
                    error_count++;
                end
                if (m_byte_index !== want.byte_index) begin
                    $error("byte_index: expected %0d, actual %0d",
                           want.byte_index, m_byte_index);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_last);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic push_beat(input logic [7:0] data, input logic [7:0] idx,
                             input logic last, input status_t st);
        rx_beat_t beat;
        beat.data_byte  = data;
        beat.byte_index = idx;
        beat.last       = last;
        beat.status     = st;
        expected_beats.push_back(beat);
        beats_predicted++;
    endtask

    task automatic return_to_hunt();
        rx_phase  = PH_HUNT;
        rx_count  = 8'd0;
        rx_length = 8'd0;
        rx_xor    = 8'd0;
        rx_timer  = 16'd0;
    endtask

    task automatic predict_frame_step(input logic cmd, input logic [7:0] b);
        logic [7:0] idx;
        if (cmd == CMD_TICK) begin
            if (rx_phase != PH_HUNT) begin
                if (rx_timer != TIMER_MAX) rx_timer = rx_timer + 16'd1;
                if (rx_timer >= cfg_timeout) begin
                    idx = rx_count;
                    return_to_hunt();
                    push_beat(8'd0, idx, 1'b1, ST_TIMEOUT);
                end
            end
        end else begin
            case (rx_phase)
                PH_HUNT: begin
                    if (b == cfg_hdr_a || b == cfg_hdr_b) begin
                        rx_xor    = b;
                        rx_count  = 8'd1;
                        rx_length = 8'd0;
                        rx_timer  = 16'd0;
                        rx_phase  = PH_LEN;
                        push_beat(b, 8'd0, 1'b0, ST_BUSY);
                    end
                end
                PH_LEN: begin
                    if (b < MIN_FRAME_LEN) begin
                        return_to_hunt();
                        push_beat(b, 8'd1, 1'b1, ST_BADLEN);
                    end else begin
                        rx_length = b;
                        rx_xor    = rx_xor ^ b;
                        rx_count  = 8'd2;
                        rx_timer  = 16'd0;
                        rx_phase  = PH_BODY;
                        push_beat(b, 8'd1, 1'b0, ST_BUSY);
                    end
                end
                default: begin
                    idx = rx_count;
                    if ({1'b0, rx_count} + 9'd1 >= {1'b0, rx_length}) begin
                        if (b == rx_xor) begin
                            return_to_hunt();
                            push_beat(b, idx, 1'b1, ST_GOOD);
                        end else begin
                            return_to_hunt();
                            push_beat(b, idx, 1'b1, ST_CSUM);
                        end
                    end else begin
                        rx_xor   = rx_xor ^ b;
                        rx_count = rx_count + 8'd1;
                        push_beat(b, idx, 1'b0, ST_BUSY);
                    end
                end
            endcase
        end
    endtask

    // called just after a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input logic cmd, input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_frame_step(cmd, b);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HEADER_FIRST:  cfg_hdr_a   = data[7:0];
            REG_HEADER_SECOND: cfg_hdr_b   = data[7:0];
            REG_TIMEOUT_TICKS: cfg_timeout = data;
            default: ;
        endcase
    endtask

    task automatic send_ticks(input int tick_pct);
        while ($urandom_range(0, 99) < tick_pct) send_item(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len,
                              input logic good, input int tick_pct);
        logic [7:0] sum;
        logic [7:0] b;
        send_item(CMD_BYTE, hdr);
        send_ticks(tick_pct);
        send_item(CMD_BYTE, len);
        sum = hdr ^ len;
        for (int i = 2; i < int'(len) - 1; i++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            send_item(CMD_BYTE, b);
            send_ticks(tick_pct);
        end
        if (!good) sum = sum ^ 8'($urandom_range(1, 255));
        send_item(CMD_BYTE, sum);
    endtask

    task automatic resync_to_hunt();
        logic [7:0] b;
        while (rx_phase != PH_HUNT) begin
            b = (rx_phase == PH_LEN) ? 8'd0 : 8'($urandom);
            send_item(CMD_BYTE, b);
        end
    endtask

    task automatic randomize_config();
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] t;
        case ($urandom_range(0, 3))
            0: begin a = 8'h00; b = 8'hFF; end
            1: begin a = 8'($urandom); b = a; end
            default: begin a = 8'($urandom); b = 8'($urandom); end
        endcase
        case ($urandom_range(0, 5))
            0: t = 16'd1;
            1: t = 16'hFFFF;
            2: t = TIMEOUT_TICKS_RST;
            default: t = 16'($urandom_range(2, 40));
        endcase
        write_reg(REG_HEADER_FIRST, {8'($urandom), a});
        write_reg(REG_HEADER_SECOND, {8'($urandom), b});
        write_reg(REG_TIMEOUT_TICKS, t);
    endtask

    task automatic random_traffic_group();
        int         pick;
        int         tick_pct;
        int         n;
        logic [7:0] len;
        logic [7:0] hdr;
        pick = $urandom_range(0, 99);
        hdr  = $urandom_range(0, 1) ? cfg_hdr_a : cfg_hdr_b;
        if (pick < 88) resync_to_hunt();
        if (pick < 70) begin
            if ($urandom_range(0, 24) == 0) len = 8'($urandom_range(17, 255));
            else len = 8'($urandom_range(3, 16));
            case ($urandom_range(0, 3))
                0, 1: tick_pct = 0;
                2: tick_pct = 5;
                default: tick_pct = 25;
            endcase
            send_frame(hdr, len, $urandom_range(0, 4) != 0, tick_pct);
        end else if (pick < 78) begin
            send_item(CMD_BYTE, hdr);
            send_item(CMD_BYTE, 8'($urandom_range(0, 2)));
        end else if (pick < 88) begin
            // frame cut short, then ticks that run out the timer if the timeout is between 1 and 64
            send_item(CMD_BYTE, hdr);
            if ($urandom_range(0, 1)) begin
                len = 8'($urandom_range(3, 20));
                send_item(CMD_BYTE, len);
                repeat ($urandom_range(0, int'(len) - 3)) send_item(CMD_BYTE, 8'($urandom));
            end
            n = (cfg_timeout <= 16'd64) ? int'(cfg_timeout) : int'($urandom_range(1, 5));
            repeat (n) send_item(CMD_TICK, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int start;
        int last_cfg;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        randomize_config();
        start    = items_sent;
        last_cfg = beats_predicted;
        while (items_sent - start < ITEMS_PER_PHASE) begin
            if (beats_predicted - last_cfg >= 120) begin
                randomize_config();
                last_cfg = beats_predicted;
            end
            random_traffic_group();
        end
    endtask

    task automatic test_good_frames();
        send_frame(HEADER_FIRST_RST, 8'd3, 1'b1, 0);
        // header values inside a frame are plain data
        send_item(CMD_BYTE, HEADER_SECOND_RST);
        send_item(CMD_BYTE, 8'd4);
        send_item(CMD_BYTE, HEADER_FIRST_RST);
        send_item(CMD_BYTE, HEADER_SECOND_RST ^ 8'd4 ^ HEADER_FIRST_RST);
        send_frame(HEADER_SECOND_RST, 8'd4, 1'b0, 0);
    endtask

    task automatic test_hunt_filtering();
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_TICK, 8'hFF);
    endtask

    task automatic test_bad_length();
        send_item(CMD_BYTE, HEADER_FIRST_RST);
        send_item(CMD_BYTE, 8'd0);
        send_item(CMD_BYTE, HEADER_SECOND_RST);
        send_item(CMD_BYTE, 8'd2);
    endtask

    task automatic test_timeouts();
        write_reg(REG_TIMEOUT_TICKS, 16'd2);
        send_item(CMD_BYTE, HEADER_FIRST_RST);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, HEADER_FIRST_RST);
        send_item(CMD_BYTE, 8'd5);
        send_item(CMD_BYTE, 8'h5A);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        // zero acts as a single tick
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        send_item(CMD_BYTE, HEADER_SECOND_RST);
        send_item(CMD_TICK, 8'h00);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_HEADER_FIRST, 16'hFF00);
        write_reg(REG_HEADER_SECOND, 16'h00FF);
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(CMD_BYTE, HEADER_FIRST_RST);
        send_frame(8'h00, 8'd3, 1'b1, 0);
        send_frame(8'hFF, 8'd3, 1'b1, 50);
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(87, 0);
        run_random_phase(0, 87);
        run_random_phase(19, 19);
    endtask

    initial begin
        cfg_hdr_a   = HEADER_FIRST_RST;
        cfg_hdr_b   = HEADER_SECOND_RST;
        cfg_timeout = TIMEOUT_TICKS_RST;
        return_to_hunt();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_good_frames();
        test_hunt_filtering();
        test_bad_length();
        test_timeouts();
        test_register_extremes();
        test_random_traffic();

        drain();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
